>>> hw/rtl/keypad_code_lock_core_assert.svh
// Assertion macros for the checker file of the code lock.
`ifndef KEYPAD_CODE_LOCK_CORE_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define KCL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define KCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define KCL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/kcl_pkg.sv
package kcl_pkg;

   localparam int RAW_W      = 6;
   localparam int TIMER_W    = 8;
   localparam int DIGIT_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int POS_W      = 2;

   localparam int KEY_LOCK   = 4;
   localparam int KEY_UNLOCK = 5;
   localparam int IND_LOCK   = 0;
   localparam int IND_UNLOCK = 1;

   localparam logic [TIMER_W-1:0] CNT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_SECRET_CODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_THR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_TIMEOUT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGIT_ACK      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESULT_SHOW    = 3'd4;

   localparam logic [CSR_DATA_W-1:0] RST_SECRET_CODE   = 8'd0;
   localparam logic [CSR_DATA_W-1:0] RST_DEBOUNCE_THR  = 8'd3;
   localparam logic [CSR_DATA_W-1:0] RST_ENTRY_TIMEOUT = 8'd10;
   localparam logic [CSR_DATA_W-1:0] RST_DIGIT_ACK     = 8'd2;
   localparam logic [CSR_DATA_W-1:0] RST_RESULT_SHOW   = 8'd10;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_DIGIT   = 3'd1,
      EV_OK      = 3'd2,
      EV_BAD     = 3'd3,
      EV_TIMEOUT = 3'd4
   } kcl_event_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] secret_code;
      logic [TIMER_W-1:0]    debounce_threshold;
      logic [TIMER_W-1:0]    entry_timeout_ticks;
      logic [TIMER_W-1:0]    digit_ack_ticks;
      logic [TIMER_W-1:0]    result_show_ticks;
   } kcl_cfg_type;

   typedef struct packed {
      logic               door_locked;
      logic               outdoor_lock_led;
      logic               outdoor_unlock_led;
      kcl_event_type      entry_event;
      logic [POS_W-1:0]   entry_position;
   } kcl_result_type;

endpackage

>>> hw/rtl/kcl_debounce.sv
module kcl_debounce import kcl_pkg::*; #(
   parameter int DIGIT_KEYS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [RAW_W-1:0]   raw,
   input  logic [TIMER_W-1:0] threshold,
   output logic [RAW_W-1:0]   press
);

   for (genvar gi = 0; gi < RAW_W; gi++) begin : g_btn
      if (gi < DIGIT_KEYS || gi >= KEY_LOCK) begin : g_used
         logic               level_ff, level_in;
         logic [TIMER_W-1:0] count_ff, count_in, count_up;
         logic               press_bit;

         always_comb begin
            // saturate so a threshold of all ones never accepts a change
            count_up  = (count_ff == CNT_MAX) ? count_ff : count_ff + TIMER_W'(1);
            level_in  = level_ff;
            count_in  = count_ff;
            press_bit = 1'b0;
            if (step_en) begin
               if (raw[gi] != level_ff) begin
                  if (count_up > threshold) begin
                     level_in  = raw[gi];
                     count_in  = '0;
                     press_bit = raw[gi];
                  end else begin
                     count_in = count_up;
                  end
               end else begin
                  count_in = '0;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               level_ff <= 1'b0;
               count_ff <= '0;
            end else begin
               level_ff <= level_in;
               count_ff <= count_in;
            end
         end

         assign press[gi] = press_bit;
      end else begin : g_unused
         assign press[gi] = 1'b0;
      end
   end

endmodule

>>> hw/rtl/kcl_ctrl.sv
module kcl_ctrl import kcl_pkg::*; #(
   parameter int DIGIT_KEYS  = 4,
   parameter int CODE_DIGITS = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  kcl_cfg_type     cfg,
   input  logic [RAW_W-1:0] press,
   output logic            deb_en,
   output kcl_result_type  result
);

   logic [POS_W-1:0]   cursor_ff, cursor_in, cursor_mid;
   logic [TIMER_W-1:0] entry_ff, entry_in, entry_mid;
   logic [TIMER_W-1:0] hold_ff, hold_in, hold_pre;
   logic [TIMER_W-1:0] ind_t_ff [2];
   logic [TIMER_W-1:0] ind_t_in [2];
   logic [TIMER_W-1:0] ind_t_mid [2];
   logic [1:0]         ind_on_ff, ind_on_in, ind_on_mid;
   logic               locked_ff, locked_in;
   logic [DIGIT_W-1:0] digit_ff [CODE_DIGITS];
   logic [DIGIT_W-1:0] digit_in [CODE_DIGITS];
   kcl_event_type      ev_mid, ev_in;
   logic [POS_W:0]     pos_v;
   logic               match;

   // timers and entry timeout, ahead of the buttons
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         ind_t_mid[k]  = ind_t_ff[k];
         ind_on_mid[k] = ind_on_ff[k];
         if (ind_t_ff[k] != '0) begin
            ind_t_mid[k] = ind_t_ff[k] - TIMER_W'(1);
            if (ind_t_ff[k] == TIMER_W'(1)) begin
               ind_on_mid[k] = 1'b0;
            end
         end
      end
      entry_mid  = entry_ff;
      cursor_mid = cursor_ff;
      hold_pre   = hold_ff;
      ev_mid     = EV_NONE;
      if (entry_ff != '0) begin
         entry_mid = entry_ff - TIMER_W'(1);
         if (entry_ff == TIMER_W'(1)) begin
            cursor_mid           = '0;
            ind_on_mid[IND_LOCK] = 1'b1;
            ind_t_mid[IND_LOCK]  = cfg.result_show_ticks;
            hold_pre             = cfg.result_show_ticks;
            ev_mid               = EV_TIMEOUT;
         end
      end
   end

   assign deb_en = step_en && (hold_pre == '0);

   // accepted presses in key order
   always_comb begin
      cursor_in = cursor_mid;
      entry_in  = entry_mid;
      ind_t_in  = ind_t_mid;
      ind_on_in = ind_on_mid;
      hold_in   = (hold_pre != '0) ? hold_pre - TIMER_W'(1) : hold_pre;
      locked_in = locked_ff;
      digit_in  = digit_ff;
      ev_in     = ev_mid;
      pos_v     = '0;
      match     = 1'b0;
      for (int i = 0; i < DIGIT_KEYS; i++) begin
         if (press[i]) begin
            entry_in  = cfg.entry_timeout_ticks;
            locked_in = 1'b1;
            for (int k = 0; k < CODE_DIGITS; k++) begin
               if (cursor_in == POS_W'(k)) begin
                  digit_in[k] = DIGIT_W'(i);
               end
            end
            pos_v                  = {1'b0, cursor_in} + (POS_W+1)'(1);
            cursor_in              = pos_v[POS_W-1:0];
            ind_on_in[IND_UNLOCK]  = 1'b1;
            ind_t_in[IND_UNLOCK]   = cfg.digit_ack_ticks;
            hold_in                = cfg.digit_ack_ticks;
            ev_in                  = EV_DIGIT;
            if (pos_v >= (POS_W+1)'(CODE_DIGITS)) begin
               cursor_in = '0;
               entry_in  = '0;
               match     = 1'b1;
               for (int k = 0; k < CODE_DIGITS; k++) begin
                  if (digit_in[k] != cfg.secret_code[DIGIT_W*k +: DIGIT_W]) begin
                     match = 1'b0;
                  end
               end
               hold_in = cfg.result_show_ticks;
               if (match) begin
                  locked_in             = 1'b0;
                  ind_on_in[IND_UNLOCK] = 1'b1;
                  ind_t_in[IND_UNLOCK]  = cfg.result_show_ticks;
                  ev_in                 = EV_OK;
               end else begin
                  ind_on_in[IND_LOCK] = 1'b1;
                  ind_t_in[IND_LOCK]  = cfg.result_show_ticks;
                  ev_in               = EV_BAD;
               end
            end
         end
      end
      if (press[KEY_LOCK]) begin
         locked_in = 1'b1;
      end
      if (press[KEY_UNLOCK]) begin
         locked_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         entry_ff  <= '0;
         hold_ff   <= '0;
         ind_t_ff  <= '{default: '0};
         ind_on_ff <= '0;
         locked_ff <= 1'b1;
      end else if (step_en) begin
         cursor_ff <= cursor_in;
         entry_ff  <= entry_in;
         hold_ff   <= hold_in;
         ind_t_ff  <= ind_t_in;
         ind_on_ff <= ind_on_in;
         locked_ff <= locked_in;
      end
   end

   // digits are only read after being written in the same entry
   always_ff @(posedge clock) begin
      if (step_en) begin
         digit_ff <= digit_in;
      end
   end

   assign result.door_locked        = locked_in;
   assign result.outdoor_lock_led   = ind_on_in[IND_LOCK];
   assign result.outdoor_unlock_led = ind_on_in[IND_UNLOCK];
   assign result.entry_event        = ev_in;
   assign result.entry_position     = cursor_in;

endmodule

>>> hw/rtl/keypad_code_lock_core.sv
// Keypad code lock with debounced buttons.
// req_ channel: one beat per controller tick, carrying the six raw button
//   levels (bits 0-3 digit keys, bit 4 lock, bit 5 unlock).
// rsp_ channel: exactly one beat per request beat, in order: door state,
//   the two outdoor lamps, the entry event of that tick and the entry position.
// csr_ channel: register writes by index (0 secret code, 1 debounce threshold,
//   2 entry timeout, 3 digit acknowledge time, 4 result show time); always
//   ready, write only while the block is idle.
// Path: a request beat is held in the input register, then its result is
//   loaded into the result register, which drives the response beat.
// Throughput: one beat per cycle while rsp_ready is high; the whole tick
//   update is one pass of logic between the input and result registers.
// Stall: while rsp_ready is low the result register holds its beat and the
//   input register can still take one more beat; then req_ready drops.
// Reset: both registers empty, registers at their defaults, door locked,
//   lamps off, no entry in progress, all buttons seen as released.
module keypad_code_lock_core import kcl_pkg::*; #(
   parameter int DIGIT_KEYS  = 4,
   parameter int CODE_DIGITS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [RAW_W-1:0]      req_raw_buttons,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_door_locked,
   output logic                  rsp_outdoor_lock_led,
   output logic                  rsp_outdoor_unlock_led,
   output logic [2:0]            rsp_entry_event,
   output logic [POS_W-1:0]      rsp_entry_position,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic             in_valid_ff;
   logic [RAW_W-1:0] raw_ff;
   logic             rsp_valid_ff;
   kcl_result_type   result_ff, result_in;
   kcl_cfg_type      cfg_ff;
   logic             advance;
   logic             deb_en;
   logic [RAW_W-1:0] press;

   // advance the held tick whenever the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.secret_code         <= RST_SECRET_CODE;
         cfg_ff.debounce_threshold  <= RST_DEBOUNCE_THR;
         cfg_ff.entry_timeout_ticks <= RST_ENTRY_TIMEOUT;
         cfg_ff.digit_ack_ticks     <= RST_DIGIT_ACK;
         cfg_ff.result_show_ticks   <= RST_RESULT_SHOW;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SECRET_CODE:   cfg_ff.secret_code         <= csr_wdata;
            CSR_DEBOUNCE_THR:  cfg_ff.debounce_threshold  <= csr_wdata;
            CSR_ENTRY_TIMEOUT: cfg_ff.entry_timeout_ticks <= csr_wdata;
            CSR_DIGIT_ACK:     cfg_ff.digit_ack_ticks     <= csr_wdata;
            CSR_RESULT_SHOW:   cfg_ff.result_show_ticks   <= csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // input register: hold the beat until the tick logic takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         raw_ff <= req_raw_buttons;
      end
   end

   kcl_debounce #(
      .DIGIT_KEYS (DIGIT_KEYS)
   ) u_debounce (
      .clock     (clock),
      .reset     (reset),
      .step_en   (deb_en),
      .raw       (raw_ff),
      .threshold (cfg_ff.debounce_threshold),
      .press     (press)
   );

   kcl_ctrl #(
      .DIGIT_KEYS  (DIGIT_KEYS),
      .CODE_DIGITS (CODE_DIGITS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cfg     (cfg_ff),
      .press   (press),
      .deb_en  (deb_en),
      .result  (result_in)
   );

   // result register: load on advance, drop the beat once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_door_locked        = result_ff.door_locked;
   assign rsp_outdoor_lock_led   = result_ff.outdoor_lock_led;
   assign rsp_outdoor_unlock_led = result_ff.outdoor_unlock_led;
   assign rsp_entry_event        = result_ff.entry_event;
   assign rsp_entry_position     = result_ff.entry_position;

endmodule

>>> hw/rtl/kcl_checker.sv
`include "keypad_code_lock_core_assert.svh"

module kcl_checker import kcl_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_door_locked,
   input logic             rsp_outdoor_lock_led,
   input logic             rsp_outdoor_unlock_led,
   input logic [2:0]       rsp_entry_event,
   input logic [POS_W-1:0] rsp_entry_position
);

   `KCL_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "response after reset")

   `KCL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_door_locked) && $stable(rsp_entry_event) && $stable(rsp_entry_position), "stalled response changed")

   `KCL_ASSERT_IMPLY(a_ok_lamp, clock, reset, rsp_valid && rsp_entry_event == EV_OK, rsp_outdoor_unlock_led && rsp_entry_position == '0, "code correct without unlock lamp or with entry left")

   `KCL_ASSERT_IMPLY(a_fail_lamp, clock, reset, rsp_valid && (rsp_entry_event == EV_BAD || rsp_entry_event == EV_TIMEOUT), rsp_outdoor_lock_led && rsp_entry_position == '0, "failure without lock lamp or with entry left")

   `KCL_ASSERT_IMPLY(a_digit_ack, clock, reset, rsp_valid && rsp_entry_event == EV_DIGIT, rsp_outdoor_unlock_led && rsp_entry_position != '0, "digit without acknowledge")

endmodule

bind keypad_code_lock_core kcl_checker u_kcl_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_door_locked        (rsp_door_locked),
   .rsp_outdoor_lock_led   (rsp_outdoor_lock_led),
   .rsp_outdoor_unlock_led (rsp_outdoor_unlock_led),
   .rsp_entry_event        (rsp_entry_event),
   .rsp_entry_position     (rsp_entry_position)
);

>>> sim/testbench.sv
module testbench;
   import kcl_pkg::*;

   localparam int DIGIT_KEYS  = 4;
   localparam int CODE_DIGITS = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_SETTLE = 4;

   localparam logic [RAW_W-1:0] LOCK_KEY_BIT   = RAW_W'(1 << KEY_LOCK);
   localparam logic [RAW_W-1:0] UNLOCK_KEY_BIT = RAW_W'(1 << KEY_UNLOCK);

   // Tracks the lock as the block should see it: registers, debounce state,
   // entry progress, lamps and hold, plus the responses still owed.
   class lock_tick_ledger;
      kcl_cfg_type    regs;
      kcl_result_type awaited[$];
      int             mismatches;
      int             ticks_checked;
      int             event_tally[5];

      bit             level[6];
      logic [7:0]     bounce[6];
      logic [1:0]     digits[4];
      logic [1:0]     cursor;
      logic [7:0]     entry_left;
      logic [7:0]     lamp_left[2];
      bit             lamp_on[2];
      logic [7:0]     hold_left;
      bit             locked;
      kcl_event_type  last_event;

      function new();
         regs.secret_code         = RST_SECRET_CODE;
         regs.debounce_threshold  = RST_DEBOUNCE_THR;
         regs.entry_timeout_ticks = RST_ENTRY_TIMEOUT;
         regs.digit_ack_ticks     = RST_DIGIT_ACK;
         regs.result_show_ticks   = RST_RESULT_SHOW;
         for (int i = 0; i < 6; i++) begin
            level[i]  = 1'b0;
            bounce[i] = '0;
         end
         for (int k = 0; k < 4; k++) digits[k] = '0;
         for (int k = 0; k < 2; k++) begin
            lamp_left[k] = '0;
            lamp_on[k]   = 1'b0;
         end
         cursor        = '0;
         entry_left    = '0;
         hold_left     = '0;
         locked        = 1'b1;
         last_event    = EV_NONE;
         mismatches    = 0;
         ticks_checked = 0;
         for (int e = 0; e < 5; e++) event_tally[e] = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_SECRET_CODE:   regs.secret_code         = val;
            CSR_DEBOUNCE_THR:  regs.debounce_threshold  = val;
            CSR_ENTRY_TIMEOUT: regs.entry_timeout_ticks = val;
            CSR_DIGIT_ACK:     regs.digit_ack_ticks     = val;
            CSR_RESULT_SHOW:   regs.result_show_ticks   = val;
            default: ;
         endcase
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void light(int which, logic [7:0] ticks);
         lamp_on[which]   = 1'b1;
         lamp_left[which] = ticks;
         hold_left        = ticks;
      endfunction

      function bit code_matches();
         for (int k = 0; k < CODE_DIGITS; k++)
            if (digits[k] != regs.secret_code[2*k +: 2]) return 1'b0;
         return 1'b1;
      endfunction

      function void take_digit(int key);
         int pos;
         entry_left     = regs.entry_timeout_ticks;
         locked         = 1'b1;
         digits[cursor] = key[1:0];
         pos            = cursor + 1;
         cursor         = pos[1:0];
         light(IND_UNLOCK, regs.digit_ack_ticks);
         last_event     = EV_DIGIT;
         if (pos >= CODE_DIGITS) begin
            cursor     = '0;
            entry_left = '0;
            if (code_matches()) begin
               locked = 1'b0;
               light(IND_UNLOCK, regs.result_show_ticks);
               last_event = EV_OK;
            end else begin
               light(IND_LOCK, regs.result_show_ticks);
               last_event = EV_BAD;
            end
         end
      endfunction

      function void key_pressed(int idx);
         if (idx < DIGIT_KEYS) take_digit(idx);
         else if (idx == KEY_LOCK) locked = 1'b1;
         else if (idx == KEY_UNLOCK) locked = 1'b0;
      endfunction

      function void scan_keys(logic [RAW_W-1:0] raw);
         bit lvl;
         for (int i = 0; i < 6; i++) begin
            if (i >= DIGIT_KEYS && i < KEY_LOCK) continue;
            lvl = raw[i];
            if (lvl != level[i]) begin
               if (bounce[i] < CNT_MAX) bounce[i]++;
               if (bounce[i] > regs.debounce_threshold) begin
                  level[i]  = lvl;
                  bounce[i] = '0;
                  if (lvl) key_pressed(i);
               end
            end else begin
               bounce[i] = '0;
            end
         end
      endfunction

      // Advance one tick and queue the response it should produce.
      function void note_tick(logic [RAW_W-1:0] raw);
         kcl_result_type r;
         last_event = EV_NONE;
         for (int k = 0; k < 2; k++) begin
            if (lamp_left[k] > 0) begin
               lamp_left[k]--;
               if (lamp_left[k] == 0) lamp_on[k] = 1'b0;
            end
         end
         if (entry_left > 0) begin
            entry_left--;
            if (entry_left == 0) begin
               cursor = '0;
               light(IND_LOCK, regs.result_show_ticks);
               last_event = EV_TIMEOUT;
            end
         end
         if (hold_left > 0) hold_left--;
         else scan_keys(raw);
         r.door_locked        = locked;
         r.outdoor_lock_led   = lamp_on[IND_LOCK];
         r.outdoor_unlock_led = lamp_on[IND_UNLOCK];
         r.entry_event        = last_event;
         r.entry_position     = cursor;
         awaited.push_back(r);
      endfunction

      function void check_result(logic door, logic lock_led, logic unlock_led,
                                 logic [2:0] ev, logic [POS_W-1:0] pos);
         kcl_result_type want;
         if (awaited.size() == 0) begin
            $error("response beat with no tick waiting for it");
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         ticks_checked++;
         event_tally[want.entry_event]++;
         if (door !== want.door_locked) begin
            $error("door_locked: expected %0d, got %0d", want.door_locked, door);
            mismatches++;
         end
         if (lock_led !== want.outdoor_lock_led) begin
            $error("outdoor_lock_led: expected %0d, got %0d", want.outdoor_lock_led, lock_led);
            mismatches++;
         end
         if (unlock_led !== want.outdoor_unlock_led) begin
            $error("outdoor_unlock_led: expected %0d, got %0d",
                   want.outdoor_unlock_led, unlock_led);
            mismatches++;
         end
         if (ev !== want.entry_event) begin
            $error("entry_event: expected %0d, got %0d", want.entry_event, ev);
            mismatches++;
         end
         if (pos !== want.entry_position) begin
            $error("entry_position: expected %0d, got %0d", want.entry_position, pos);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [RAW_W-1:0]      req_raw_buttons = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic                  rsp_door_locked;
   logic                  rsp_outdoor_lock_led;
   logic                  rsp_outdoor_unlock_led;
   logic [2:0]            rsp_entry_event;
   logic [POS_W-1:0]      rsp_entry_position;
   logic                  csr_valid       = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   lock_tick_ledger ledger = new();

   // Stimulus bookkeeping shared by the driving tasks.
   kcl_cfg_type settings;
   int          items_sent     = 0;
   int          phase_end      = 0;
   int          settings_count = 0;
   int          idle_rate      = 0;   // chance of an idle burst, out of 16
   bit          quiet          = 1'b0; // no idling at all once set
   int          cycles         = 0;
   int          stall_left     = 0;

   keypad_code_lock_core #(
      .DIGIT_KEYS  (DIGIT_KEYS),
      .CODE_DIGITS (CODE_DIGITS)
   ) DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_raw_buttons        (req_raw_buttons),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_door_locked        (rsp_door_locked),
      .rsp_outdoor_lock_led   (rsp_outdoor_lock_led),
      .rsp_outdoor_unlock_led (rsp_outdoor_unlock_led),
      .rsp_entry_event        (rsp_entry_event),
      .rsp_entry_position     (rsp_entry_position),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Response side: drop ready in random bursts, never once the closing
   // stretch has begun.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(1, 16) <= idle_rate) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check every response beat against the oldest predicted tick.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_result(rsp_door_locked, rsp_outdoor_lock_led, rsp_outdoor_unlock_led,
                             rsp_entry_event, rsp_entry_position);
   end

   // Offer one tick of button levels. Call at a falling edge; return at the
   // falling edge after the beat is taken, with valid still high so that a
   // following tick goes out back to back.
   task automatic send_tick(logic [RAW_W-1:0] raw);
      int gap;
      if (!quiet && $urandom_range(1, 16) <= idle_rate) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_raw_buttons <= raw;
      do @(posedge clock); while (!req_ready);
      ledger.note_tick(raw);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold one set of levels for n ticks, stopping at the end of the phase.
   task automatic hold_level(logic [RAW_W-1:0] raw, int n);
      for (int j = 0; j < n; j++)
         if (items_sent < phase_end) send_tick(raw);
   endtask

   // Press and release a set of keys: long enough to pass the debounce,
   // sometimes with contact chatter first, and a release that may or may not
   // outlast the hold after a digit.
   task automatic tap(logic [RAW_W-1:0] keys);
      int settle;
      settle = settings.debounce_threshold + 1;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            hold_level(keys, 1);
            hold_level('0, 1);
         end
      end
      hold_level(keys, settle + $urandom_range(0, 3));
      hold_level('0, settle + $urandom_range(0, settings.digit_ack_ticks + 2));
   endtask

   // One user action: mostly a full code entry (half of them the right code),
   // else a lock or unlock key, else random chatter on all buttons.
   task automatic play_gesture();
      int               kind;
      bit               genuine;
      logic [1:0]       d;
      logic [RAW_W-1:0] keys;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         genuine = 1'($urandom_range(0, 1));
         for (int k = 0; k < CODE_DIGITS; k++) begin
            d = genuine ? settings.secret_code[2*k +: 2] : 2'($urandom_range(0, 3));
            keys    = '0;
            keys[d] = 1'b1;
            tap(keys);
            // Sometimes dawdle, at times long enough for the entry to time out.
            if ($urandom_range(0, 3) == 0)
               hold_level('0, $urandom_range(0, settings.entry_timeout_ticks + 2));
         end
      end else if (kind < 8) begin
         tap($urandom_range(0, 1) ? LOCK_KEY_BIT : UNLOCK_KEY_BIT);
      end else begin
         repeat ($urandom_range(1, 8)) hold_level(RAW_W'($urandom_range(0, 63)), 1);
      end
   endtask

   // Write all five registers once the block has drained. Call at a falling
   // edge; returns at a falling edge with the request side idle.
   task automatic apply_settings(kcl_cfg_type s);
      logic [CSR_IDX_W-1:0]  idx[5];
      logic [CSR_DATA_W-1:0] val[5];
      idx[0] = CSR_SECRET_CODE;   val[0] = s.secret_code;
      idx[1] = CSR_DEBOUNCE_THR;  val[1] = s.debounce_threshold;
      idx[2] = CSR_ENTRY_TIMEOUT; val[2] = s.entry_timeout_ticks;
      idx[3] = CSR_DIGIT_ACK;     val[3] = s.digit_ack_ticks;
      idx[4] = CSR_RESULT_SHOW;   val[4] = s.result_show_ticks;
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
         ledger.write_reg(idx[i], val[i]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      settings = s;
      settings_count++;
   endtask

   function automatic kcl_cfg_type random_settings();
      kcl_cfg_type s;
      s.secret_code         = 8'($urandom_range(0, 255));
      s.debounce_threshold  = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(7, 20)
                                                              : $urandom_range(0, 6));
      s.entry_timeout_ticks = 8'($urandom_range(1, 40));
      s.digit_ack_ticks     = 8'($urandom_range(1, 8));
      s.result_show_ticks   = 8'($urandom_range(1, 15));
      return s;
   endfunction

   task automatic run_phase(kcl_cfg_type s, int budget);
      apply_settings(s);
      phase_end = items_sent + budget;
      case ($urandom_range(0, 2))
         0:       idle_rate = 0;
         1:       idle_rate = 2;
         default: idle_rate = 5;
      endcase
      while (items_sent < phase_end) play_gesture();
   endtask

   initial begin
      logic [RAW_W-1:0] drill[$];
      kcl_cfg_type      s;
      bit               failed;

      settings.secret_code         = RST_SECRET_CODE;
      settings.debounce_threshold  = RST_DEBOUNCE_THR;
      settings.entry_timeout_ticks = RST_ENTRY_TIMEOUT;
      settings.digit_ack_ticks     = RST_DIGIT_ACK;
      settings.result_show_ticks   = RST_RESULT_SHOW;

      // Hold reset, then release it away from the edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Opening drill. Lock and unlock together under the reset-time
      // debounce: the pair is taken on the fourth tick, unlock last.
      idle_rate = 4;
      phase_end = items_sent + 4;
      hold_level(LOCK_KEY_BIT | UNLOCK_KEY_BIT, 4);

      // Fast settings: every key at once (four digits in one tick, a wrong
      // code, then lock and unlock), the right code 1-2-3-0 a key at a time,
      // a stray digit afterwards, then lock and unlock on their own.
      s.secret_code         = 8'h39;
      s.debounce_threshold  = 8'd0;
      s.entry_timeout_ticks = 8'd4;
      s.digit_ack_ticks     = 8'd1;
      s.result_show_ticks   = 8'd1;
      apply_settings(s);
      drill = '{6'h00, 6'h3F, 6'h00, 6'h00, 6'h02, 6'h00, 6'h00, 6'h04, 6'h00, 6'h00,
                6'h08, 6'h00, 6'h00, 6'h01, 6'h00, 6'h00, 6'h01, 6'h00, 6'h10, 6'h00,
                6'h20};
      phase_end = items_sent + drill.size();
      foreach (drill[i]) send_tick(drill[i]);

      // Shortest times and no debounce.
      s.secret_code         = 8'h00;
      s.debounce_threshold  = 8'd0;
      s.entry_timeout_ticks = 8'd1;
      s.digit_ack_ticks     = 8'd1;
      s.result_show_ticks   = 8'd1;
      run_phase(s, 200);

      // Slowest debounce: each change needs 255 steady ticks.
      s.secret_code         = 8'hFF;
      s.debounce_threshold  = 8'd254;
      s.entry_timeout_ticks = 8'd255;
      s.digit_ack_ticks     = 8'd1;
      s.result_show_ticks   = 8'd1;
      run_phase(s, 560);

      // Longest lamp, hold and timeout times with instant debounce.
      s.secret_code         = 8'hFF;
      s.debounce_threshold  = 8'd0;
      s.entry_timeout_ticks = 8'd255;
      s.digit_ack_ticks     = 8'd255;
      s.result_show_ticks   = 8'd255;
      run_phase(s, 300);

      // Back to the power-up values.
      s.secret_code         = RST_SECRET_CODE;
      s.debounce_threshold  = RST_DEBOUNCE_THR;
      s.entry_timeout_ticks = RST_ENTRY_TIMEOUT;
      s.digit_ack_ticks     = RST_DIGIT_ACK;
      s.result_show_ticks   = RST_RESULT_SHOW;
      run_phase(s, 200);

      // Assorted settings; the last phase runs flat out with no idling.
      for (int p = 0; p < 4; p++) begin
         if (p == 3) quiet = 1'b1;
         run_phase(random_settings(), 160);
      end

      // Drain: stop offering ticks and let every owed response come back.
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);

      $display("Checked %0d ticks across %0d register settings.",
               ledger.ticks_checked, settings_count);
      $display("Seen: %0d digits taken, %0d codes accepted, %0d rejected, %0d timeouts.",
               ledger.event_tally[EV_DIGIT], ledger.event_tally[EV_OK],
               ledger.event_tally[EV_BAD], ledger.event_tally[EV_TIMEOUT]);
      failed = (ledger.mismatches != 0) || (ledger.pending() != 0);
      if (!failed) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_debounce.sv
hw/rtl/kcl_ctrl.sv
hw/rtl/keypad_code_lock_core.sv
hw/rtl/kcl_checker.sv
sim/testbench.sv
